>>> sv/pjf_pkg.sv
// Shared types and constants of the PCM jitter FIFO with prebuffer threshold.
`timescale 1ns / 1ps

package pjf_pkg;

    localparam int PCM_W        = 16;
    localparam int CNT_W        = 13;
    localparam int MAXS_W       = 7;
    localparam int CAPACITY_DEF = 4096;
    localparam int MAX_CHUNK_DEF = 64;
    localparam logic [CNT_W-1:0] PREBUF_RST = 13'd1024;

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_END   = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_NONE   = 2'd2,
        KIND_ACK    = 2'd3
    } t_kind;

    // One classified request as it travels from the front end to the back end.
    typedef struct packed {
        t_func             func;
        logic [PCM_W-1:0]  sample;
        logic              first;
        logic [CNT_W-1:0]  count;
        logic [MAXS_W-1:0] maxs;
    } t_cmd;

    // Status flags of one result; occupancy and sample travel beside it.
    typedef struct packed {
        t_kind kind;
        logic  push_full;
        logic  last;
        logic  ready_res;
        logic  end_reached;
        logic  playing;
    } t_res;

endpackage

>>> sv/pjf_front.sv
// Front end: takes requests, decodes them and saturates the pop size.
`timescale 1ns / 1ps

module pjf_front #(
    parameter int MAX_CHUNK = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                i_func,
    input  logic [pjf_pkg::PCM_W-1:0] i_sample,
    input  logic                      i_block_first,
    input  logic [pjf_pkg::CNT_W-1:0] i_block_count,
    input  logic [pjf_pkg::MAXS_W-1:0] i_max_samples,
    output logic                      o_q_push,
    input  logic                      i_q_full,
    output pjf_pkg::t_cmd             o_cmd
);
    import pjf_pkg::*;

    localparam logic [MAXS_W-1:0] CHUNK_LIM = MAXS_W'(MAX_CHUNK);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign full     = r_valid && i_q_full;
    assign accept   = push && !full;
    assign o_q_push = r_valid;
    assign o_cmd    = r_cmd;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (!i_q_full) begin
            n_valid = 1'b0;
        end
        n_cmd.func   = t_func'(i_func);
        n_cmd.sample = i_sample;
        n_cmd.first  = i_block_first;
        n_cmd.count  = i_block_count;
        n_cmd.maxs   = (i_max_samples > CHUNK_LIM) ? CHUNK_LIM : i_max_samples;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

>>> sv/pjf_cmdq.sv
// Two-entry request queue between the front end and the back end.
`timescale 1ns / 1ps

module pjf_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pjf_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pjf_pkg::t_cmd o_cmd
);
    import pjf_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       wr_en;
    logic       rd_en;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr <= ~r_wr;
            end
            if (rd_en) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= i_cmd;
        end
    end

endmodule

>>> sv/pjf_back.sv
// Back end: sample memory, occupancy and playback state, result queue.
`timescale 1ns / 1ps

module pjf_back #(
    parameter int CAPACITY = 4096,
    parameter int OCC_W    = 13
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pjf_pkg::CNT_W-1:0]     i_level,
    input  logic                          i_cmd_valid,
    input  pjf_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    output logic                          empty,
    input  logic                          pop,
    output pjf_pkg::t_res                 o_res,
    output logic [pjf_pkg::PCM_W-1:0]     o_sample,
    output logic [OCC_W-1:0]              o_buffered
);
    import pjf_pkg::*;

    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int SUM_W    = ((OCC_W > CNT_W) ? OCC_W : CNT_W) + 1;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } t_bstate;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    t_bstate           r_state, n_state;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic              r_playing, n_playing;
    logic              r_end, n_end;
    logic              r_rejected, n_rejected;
    logic [MAXS_W-1:0] r_remain, n_remain;

    logic [PCM_W-1:0]  r_mem [CAPACITY];
    logic [PCM_W-1:0]  r_rd_data;
    logic              mem_we;
    logic              mem_re;

    logic              r_s2_valid;
    t_res              r_s2;
    logic [OCC_W-1:0]  r_s2_buf;

    t_res              r_oq     [OQ_DEPTH];
    logic [PCM_W-1:0]  r_oq_smp [OQ_DEPTH];
    logic [OCC_W-1:0]  r_oq_buf [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_oq_wr;
    logic [OQ_PTR_W-1:0] r_oq_rd;
    logic [OQ_CNT_W-1:0] r_oq_cnt;
    logic              oq_rd;

    logic              space;
    logic              issue;
    t_res              res;
    logic [SUM_W-1:0]  occ_ext;
    logic              hold_back;
    logic [MAXS_W-1:0] take;

    assign occ_ext = SUM_W'(r_occ);
    assign space   = ((SUM_W'(r_oq_cnt) + SUM_W'(r_s2_valid)) < SUM_W'(OQ_DEPTH));
    assign hold_back = (r_occ == '0) || (i_cmd.maxs == '0) ||
                       (!r_playing && (occ_ext < SUM_W'(i_level)) && !r_end);
    assign take    = (SUM_W'(i_cmd.maxs) < occ_ext) ? i_cmd.maxs : MAXS_W'(r_occ);

    always_comb begin
        n_state    = r_state;
        n_rp       = r_rp;
        n_wp       = r_wp;
        n_occ      = r_occ;
        n_playing  = r_playing;
        n_end      = r_end;
        n_rejected = r_rejected;
        n_remain   = r_remain;
        o_cmd_pop  = 1'b0;
        issue      = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        res.kind      = KIND_ACK;
        res.push_full = 1'b0;
        res.last      = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && space) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.func)
                        FUNC_PUSH: begin
                            issue    = 1'b1;
                            res.kind = KIND_PUSH;
                            if (i_cmd.first) begin
                                if (i_cmd.count == '0) begin
                                    n_rejected = 1'b1;
                                end else if ((occ_ext + SUM_W'(i_cmd.count))
                                             > SUM_W'(CAPACITY)) begin
                                    n_rejected    = 1'b1;
                                    res.push_full = 1'b1;
                                end else begin
                                    n_rejected = 1'b0;
                                    mem_we     = 1'b1;
                                end
                            end else if (r_rejected || (occ_ext >= SUM_W'(CAPACITY))) begin
                                res.push_full = 1'b1;
                            end else begin
                                mem_we = 1'b1;
                            end
                            if (mem_we) begin
                                n_wp  = adv(r_wp);
                                n_occ = r_occ + 1'b1;
                            end
                        end
                        FUNC_POP: begin
                            if (hold_back) begin
                                issue    = 1'b1;
                                res.kind = KIND_NONE;
                            end else begin
                                n_playing = 1'b1;
                                n_remain  = take;
                                n_state   = ST_POP;
                            end
                        end
                        FUNC_END: begin
                            issue = 1'b1;
                            n_end = 1'b1;
                        end
                        FUNC_CLEAR: begin
                            issue      = 1'b1;
                            n_rp       = '0;
                            n_wp       = '0;
                            n_occ      = '0;
                            n_end      = 1'b0;
                            n_playing  = 1'b0;
                            n_rejected = 1'b0;
                        end
                        default: begin
                            issue = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP: begin
                if (space) begin
                    issue    = 1'b1;
                    mem_re   = 1'b1;
                    res.kind = KIND_SAMPLE;
                    res.last = (r_remain == MAXS_W'(1));
                    n_rp     = adv(r_rp);
                    n_occ    = r_occ - 1'b1;
                    n_remain = r_remain - 1'b1;
                    if (res.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        res.ready_res   = (SUM_W'(n_occ) >= SUM_W'(i_level));
        res.end_reached = n_end && (n_occ == '0);
        res.playing     = n_playing;
    end

    // Sample memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= i_cmd.sample;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rp       <= '0;
            r_wp       <= '0;
            r_occ      <= '0;
            r_playing  <= 1'b0;
            r_end      <= 1'b0;
            r_rejected <= 1'b0;
            r_remain   <= '0;
            r_s2_valid <= 1'b0;
            r_oq_wr    <= '0;
            r_oq_rd    <= '0;
            r_oq_cnt   <= '0;
        end else begin
            r_state    <= n_state;
            r_rp       <= n_rp;
            r_wp       <= n_wp;
            r_occ      <= n_occ;
            r_playing  <= n_playing;
            r_end      <= n_end;
            r_rejected <= n_rejected;
            r_remain   <= n_remain;
            r_s2_valid <= issue;
            if (r_s2_valid) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (oq_rd) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            r_oq_cnt <= r_oq_cnt + OQ_CNT_W'(r_s2_valid) - OQ_CNT_W'(oq_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s2     <= res;
            r_s2_buf <= n_occ;
        end
        if (r_s2_valid) begin
            r_oq[r_oq_wr]     <= r_s2;
            r_oq_buf[r_oq_wr] <= r_s2_buf;
            r_oq_smp[r_oq_wr] <= (r_s2.kind == KIND_SAMPLE) ? r_rd_data : '0;
        end
    end

    assign empty      = (r_oq_cnt == '0);
    assign oq_rd      = pop && !empty;
    assign o_res      = r_oq[r_oq_rd];
    assign o_sample   = r_oq_smp[r_oq_rd];
    assign o_buffered = r_oq_buf[r_oq_rd];

endmodule

>>> sv/pcm_jitter_fifo_prebuffer_core.sv
// Top level of the PCM jitter FIFO with prebuffer threshold.
`timescale 1ns / 1ps

// Channel     Direction  Handshake                 Payload
// request     in         push / full               i_func, i_sample, i_block_first,
//                                                  i_block_count, i_max_samples
// result      out        empty / pop               o_kind, o_push_full, o_out_sample,
//                                                  o_last, o_buffered, o_ready_res,
//                                                  o_end_reached, o_playing
// config      in         i_cfg_valid / o_cfg_ready i_cfg_data (prebuffer level)
//
// A push, mark-end or clear request yields one result.
// A pop that releases N samples first decides, then reads the samples one at a time,
// paced by the single read port of the sample memory.
// Reset is synchronous; the sample memory is not cleared and needs no sweep.
// A stalled result side fills the four-entry result queue, then the back end waits,
// then the two-entry request queue and the front register fill and full rises.

module pcm_jitter_fifo_prebuffer_core #(
    parameter int CAPACITY  = pjf_pkg::CAPACITY_DEF,
    parameter int MAX_CHUNK = pjf_pkg::MAX_CHUNK_DEF,
    parameter int OCC_W     = $clog2(CAPACITY + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request side.
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_func,
    input  logic signed [pjf_pkg::PCM_W-1:0]  i_sample,
    input  logic                              i_block_first,
    input  logic [pjf_pkg::CNT_W-1:0]         i_block_count,
    input  logic [pjf_pkg::MAXS_W-1:0]        i_max_samples,
    // Result side.
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        o_kind,
    output logic                              o_push_full,
    output logic signed [pjf_pkg::PCM_W-1:0]  o_out_sample,
    output logic                              o_last,
    output logic [OCC_W-1:0]                  o_buffered,
    output logic                              o_ready_res,
    output logic                              o_end_reached,
    output logic                              o_playing,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pjf_pkg::CNT_W-1:0]         i_cfg_data
);
    import pjf_pkg::*;

    // The prebuffer level is the only register; writes are always taken and
    // land on the next edge. The user must write only while idle; nothing enforces it.
    logic [CNT_W-1:0] r_level;

    // Front-to-queue and queue-to-back transfer signals.
    logic   q_push;
    logic   q_full;
    t_cmd   front_cmd;
    logic   q_valid;
    logic   q_pop;
    t_cmd   back_cmd;
    t_res   res;
    logic [PCM_W-1:0] res_sample;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= PREBUF_RST;
        end else if (i_cfg_valid) begin
            r_level <= i_cfg_data;
        end
    end

    // The front end registers and decodes one request per cycle while full is low.
    pjf_front #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_func        (i_func),
        .i_sample      (i_sample),
        .i_block_first (i_block_first),
        .i_block_count (i_block_count),
        .i_max_samples (i_max_samples),
        .o_q_push      (q_push),
        .i_q_full      (q_full),
        .o_cmd         (front_cmd)
    );

    // The request queue lets the front keep taking requests while the back end
    // streams out a long pop.
    pjf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (back_cmd)
    );

    // The back end owns the sample memory, the occupancy bookkeeping, the
    // playback round flags and the result queue.
    pjf_back #(
        .CAPACITY (CAPACITY),
        .OCC_W    (OCC_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_level     (r_level),
        .i_cmd_valid (q_valid),
        .i_cmd       (back_cmd),
        .o_cmd_pop   (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_res       (res),
        .o_sample    (res_sample),
        .o_buffered  (o_buffered)
    );

    assign o_kind        = res.kind;
    assign o_push_full   = res.push_full;
    assign o_out_sample  = res_sample;
    assign o_last        = res.last;
    assign o_ready_res   = res.ready_res;
    assign o_end_reached = res.end_reached;
    assign o_playing     = res.playing;

endmodule
